// ===== hdl/tlam_pkg.sv =====
// ----------------------------------------------------------------------------
// tlam_pkg
// Shared constants and types for the thermistor level alarm monitor.
// ----------------------------------------------------------------------------
package tlam_pkg;

    localparam int CV_W        = 9;
    localparam int CODE_W      = 8;
    localparam int NUM_BANDS   = 6;
    localparam int NUM_EDGES   = NUM_BANDS - 1;
    localparam int BAND_W      = $clog2(NUM_BANDS);
    localparam int CFG_IDX_W   = 3;

    localparam int DEBOUNCE_SAMPLES = 10;
    // Wide enough to hold DEBOUNCE_SAMPLES itself.
    localparam int CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);

    localparam logic [CV_W-1:0] FULL_SCALE_CV    = CV_W'(330);
    localparam int              UPPER_MILLI_KOHM = 47000;
    localparam int              PROD_W           = 26;

    typedef logic [BAND_W-1:0]    band_idx_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register map.
    localparam cfg_idx_t REG_BAND1_CODE      = 3'd0;
    localparam cfg_idx_t REG_ALARM_THRESHOLD = 3'd6;

    // Band edges in milliohm-kilo units (thousandths of a kOhm), highest first.
    typedef logic [13:0] edge_t;
    localparam edge_t BAND_EDGE [NUM_EDGES] = '{
        14'd10000, 14'd9287, 14'd8632, 14'd8028, 14'd7472
    };

endpackage

// ===== hdl/tlam_band.sv =====
// ----------------------------------------------------------------------------
// tlam_band
// Sorts a clamped divider voltage into one of six resistance bands by
// cross-multiplied compares against each band edge.
// ----------------------------------------------------------------------------
module tlam_band
    import tlam_pkg::*;
(
    input  logic [CV_W-1:0] cv,
    output band_idx_t       band
);

    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rest;
    logic [NUM_EDGES-1:0] hit;

    assign lhs  = PROD_W'(UPPER_MILLI_KOHM) * PROD_W'(cv);
    assign rest = PROD_W'(FULL_SCALE_CV) - PROD_W'(cv);

    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            hit[i] = (lhs >= PROD_W'(BAND_EDGE[i]) * rest);
        end
    end

    // Pick the highest edge that the resistance reaches.
    always_comb
    begin
        band = BAND_W'(NUM_BANDS - 1);
        for (int i = NUM_EDGES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                band = BAND_W'(i);
            end
        end
        // Full scale: infinite resistance
        if (cv >= FULL_SCALE_CV)
        begin
            band = '0;
        end
    end

endmodule

// ===== hdl/thermistor_level_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// thermistor_level_alarm_monitor
// Classifies thermistor divider samples into configured level codes and
// raises a debounced high temperature alarm.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | divider_centivolts
//  out      | out_valid/out_stall | level_code, alarm_active, alarm_changed
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One sample per cycle while out_stall is low; input register, then result register.
//  The band compares, code lookup and debounce update sit between them.
//  Reset clears the alarm state, the disagree count and loads the default codes.
//  A stalled result holds; an empty input register still takes a sample while
//  the result register is full and drains into it once the stall drops.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module thermistor_level_alarm_monitor
    import tlam_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,

    input  logic            in_valid,
    output logic            in_stall,
    input  logic [CV_W-1:0] divider_centivolts,

    output logic            out_valid,
    input  logic            out_stall,
    output code_t           level_code,
    output logic            alarm_active,
    output logic            alarm_changed,

    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  cfg_idx_t        cfg_index,
    input  code_t           cfg_data
);

    code_t            band_code_reg [NUM_BANDS];
    code_t            alarm_threshold_reg;

    logic             s1_valid_reg;
    logic [CV_W-1:0]  s1_cv_reg;

    logic             out_valid_reg;
    code_t            level_code_reg;
    logic             alarm_active_reg;
    logic             alarm_changed_reg;

    logic             alarm_state_reg;
    logic             alarm_state_next;
    logic [CNT_W-1:0] disagree_count_reg;
    logic [CNT_W-1:0] disagree_count_next;

    logic             out_load;
    logic             s1_load;
    band_idx_t        band;
    code_t            code;
    logic             pending;
    logic             changed;
    logic [CNT_W-1:0] count_inc;

    assign cfg_ready = 1'b1;

    // Advance the result register when it is empty or being taken.
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign s1_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                band_code_reg[i] <= CODE_W'(i + 1);
            end
            alarm_threshold_reg <= CODE_W'(5);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ALARM_THRESHOLD)
            begin
                alarm_threshold_reg <= cfg_data;
            end
            else if (cfg_index < CFG_IDX_W'(NUM_BANDS))
            begin
                band_code_reg[BAND_W'(cfg_index - REG_BAND1_CODE)] <= cfg_data;
            end
        end
    end

    // Input register; clamp above-full-scale readings on the way in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cv_reg <= (divider_centivolts > FULL_SCALE_CV) ? FULL_SCALE_CV
                                                              : divider_centivolts;
        end
    end

    tlam_band u_band
    (
        .cv   (s1_cv_reg),
        .band (band)
    );

    assign code      = band_code_reg[band];
    assign pending   = (code > alarm_threshold_reg);
    assign count_inc = disagree_count_reg + CNT_W'(1);

    always_comb
    begin
        alarm_state_next    = alarm_state_reg;
        disagree_count_next = '0;
        changed             = 1'b0;
        if (pending != alarm_state_reg)
        begin
            if (count_inc >= CNT_W'(DEBOUNCE_SAMPLES))
            begin
                alarm_state_next = pending;
                changed          = 1'b1;
            end
            else
            begin
                disagree_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_state_reg    <= 1'b0;
            disagree_count_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                alarm_state_reg    <= alarm_state_next;
                disagree_count_reg <= disagree_count_next;
                out_valid_reg      <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            level_code_reg    <= code;
            alarm_active_reg  <= alarm_state_next;
            alarm_changed_reg <= changed;
        end
    end

    assign out_valid     = out_valid_reg;
    assign level_code    = level_code_reg;
    assign alarm_active  = alarm_active_reg;
    assign alarm_changed = alarm_changed_reg;

endmodule

// ===== verif/tb_thermistor_level_alarm_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermistor_level_alarm_monitor
// Drives divider voltage samples through the level alarm monitor and checks
// each level code and debounced alarm result against a cycle-free predictor.
// Runs several register settings under different sender and receiver idling
// patterns, including a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_thermistor_level_alarm_monitor;
    import tlam_pkg::*;

    localparam cfg_idx_t UNMAPPED_REG = 3'd7;
    localparam int       HOLD_CYCLES  = 400;
    localparam int       CYCLE_LIMIT  = 400000;

    typedef struct packed {
        code_t level;
        logic  active;
        logic  changed;
    } alarm_reading_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [CV_W-1:0] divider_centivolts = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    code_t           level_code;
    logic            alarm_active;
    logic            alarm_changed;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    cfg_idx_t        cfg_index = '0;
    code_t           cfg_data = '0;

    // Register shadow and alarm state of the predictor.
    code_t band_code [NUM_BANDS];
    code_t alarm_threshold_q;
    logic  alarm_latched;
    int    disagree_run;

    logic [CV_W-1:0] pending_samples [$];
    alarm_reading_t  predicted_readings [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    thermistor_level_alarm_monitor i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .divider_centivolts (divider_centivolts),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .level_code         (level_code),
        .alarm_active       (alarm_active),
        .alarm_changed      (alarm_changed),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Classify one sample and advance the debounce state.
    function automatic alarm_reading_t predict_reading(input logic [CV_W-1:0] cv_in);
        alarm_reading_t r;
        int unsigned    cv;
        int unsigned    lhs;
        int unsigned    rest;
        int             band;
        logic           hot;
        cv = 32'((cv_in > FULL_SCALE_CV) ? FULL_SCALE_CV : cv_in);
        band = NUM_BANDS - 1;
        if (cv == FULL_SCALE_CV)
        begin
            band = 0;
        end
        else
        begin
            lhs  = UPPER_MILLI_KOHM * cv;
            rest = FULL_SCALE_CV - cv;
            // Lowest edge index that the resistance reaches wins.
            for (int e = NUM_EDGES - 1; e >= 0; e--)
            begin
                if (lhs >= BAND_EDGE[e] * rest)
                    band = e;
            end
        end
        r.level   = band_code[band];
        r.changed = 1'b0;
        hot = (r.level > alarm_threshold_q);
        if (hot != alarm_latched)
        begin
            disagree_run++;
            if (disagree_run >= DEBOUNCE_SAMPLES)
            begin
                alarm_latched = hot;
                disagree_run  = 0;
                r.changed     = 1'b1;
            end
        end
        else
        begin
            disagree_run = 0;
        end
        r.active = alarm_latched;
        return r;
    endfunction

    // Pick a voltage that lands in the given resistance band.
    function automatic logic [CV_W-1:0] cv_in_band(input int band);
        case (band)
            0:       return CV_W'($urandom_range(511, 58));
            1:       return CV_W'($urandom_range(57, 55));
            2:       return CV_W'($urandom_range(54, 52));
            3:       return CV_W'($urandom_range(51, 49));
            4:       return CV_W'($urandom_range(48, 46));
            default: return CV_W'($urandom_range(45, 0));
        endcase
    endfunction

    // Mostly runs of samples in one band, with loose samples in between.
    task automatic queue_bursts(input int n_items);
        int left;
        int run;
        int band;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(99) < 15)
            begin
                pending_samples.push_back(CV_W'($urandom_range(511)));
                left--;
            end
            else
            begin
                band = $urandom_range(NUM_BANDS - 1);
                run  = $urandom_range(24, 1);
                for (int k = 0; k < run && left > 0; k++)
                begin
                    pending_samples.push_back(cv_in_band(band));
                    left--;
                end
            end
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input code_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx >= REG_BAND1_CODE && idx < REG_BAND1_CODE + NUM_BANDS)
            band_code[idx - REG_BAND1_CODE] = value;
        else if (idx == REG_ALARM_THRESHOLD)
            alarm_threshold_q = value;
    endtask

    task automatic program_levels(input code_t c1, input code_t c2, input code_t c3,
                                  input code_t c4, input code_t c5, input code_t c6,
                                  input code_t threshold);
        write_reg(cfg_idx_t'(REG_BAND1_CODE + 0), c1);
        write_reg(cfg_idx_t'(REG_BAND1_CODE + 1), c2);
        write_reg(cfg_idx_t'(REG_BAND1_CODE + 2), c3);
        write_reg(cfg_idx_t'(REG_BAND1_CODE + 3), c4);
        write_reg(cfg_idx_t'(REG_BAND1_CODE + 4), c5);
        write_reg(cfg_idx_t'(REG_BAND1_CODE + 5), c6);
        write_reg(REG_ALARM_THRESHOLD, threshold);
    endtask

    // Hold until every sample is through and every result has been checked.
    task automatic drain;
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || predicted_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver: predict on each accepted transaction, then offer the next sample.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predicted_readings.push_back(predict_reading(divider_centivolts));
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid           <= 1'b1;
                    divider_centivolts <= pending_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        alarm_reading_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_readings.size() == 0)
                begin
                    $error("result with no sample outstanding: level_code %0d", level_code);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = predicted_readings.pop_front();
                    if (level_code !== exp_r.level)
                    begin
                        $error("level_code: expected %0d, actual %0d", exp_r.level, level_code);
                        mismatch_count++;
                    end
                    if (alarm_active !== exp_r.active)
                    begin
                        $error("alarm_active: expected %0b, actual %0b",
                               exp_r.active, alarm_active);
                        mismatch_count++;
                    end
                    if (alarm_changed !== exp_r.changed)
                    begin
                        $error("alarm_changed: expected %0b, actual %0b",
                               exp_r.changed, alarm_changed);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        for (int b = 0; b < NUM_BANDS; b++)
            band_code[b] = code_t'(b + 1);
        alarm_threshold_q = 8'd5;
        alarm_latched     = 1'b0;
        disagree_run      = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset codes: field extremes, every band edge, full scale and above.
        pending_samples.push_back(9'd0);
        pending_samples.push_back(9'd1);
        pending_samples.push_back(9'd2);
        pending_samples.push_back(9'd4);
        pending_samples.push_back(9'd8);
        pending_samples.push_back(9'd16);
        pending_samples.push_back(9'd32);
        pending_samples.push_back(9'd45);
        pending_samples.push_back(9'd46);
        pending_samples.push_back(9'd48);
        pending_samples.push_back(9'd49);
        pending_samples.push_back(9'd51);
        pending_samples.push_back(9'd52);
        pending_samples.push_back(9'd54);
        pending_samples.push_back(9'd55);
        pending_samples.push_back(9'd57);
        pending_samples.push_back(9'd58);
        pending_samples.push_back(9'd64);
        pending_samples.push_back(9'd128);
        pending_samples.push_back(9'd256);
        pending_samples.push_back(9'd329);
        pending_samples.push_back(9'd330);
        pending_samples.push_back(9'd331);
        pending_samples.push_back(9'd511);
        queue_bursts(276);
        drain();

        // Unmapped index must leave every register alone.
        write_reg(UNMAPPED_REG, 8'hFF);
        program_levels(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
        send_idle_pct  = 85;
        recv_stall_pct = 0;
        queue_bursts(300);
        drain();

        // Threshold at the top: the alarm can never be pending.
        program_levels(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        queue_bursts(300);
        drain();

        program_levels(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd35);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        queue_bursts(300);
        drain();

        // Cold bands alarm; the receiver holds off while samples keep coming.
        program_levels(8'd255, 8'd200, 8'd100, 8'd50, 8'd1, 8'd0, 8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_bursts(350);
        hold_req <= hold_req + 1;
        drain();

        program_levels(code_t'($urandom_range(255)), code_t'($urandom_range(255)),
                       code_t'($urandom_range(255)), code_t'($urandom_range(255)),
                       code_t'($urandom_range(255)), code_t'($urandom_range(255)),
                       code_t'($urandom_range(255)));
        queue_bursts(300);
        drain();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tlam_pkg.sv
hdl/tlam_band.sv
hdl/thermistor_level_alarm_monitor.sv
verif/tb_thermistor_level_alarm_monitor.sv
